// ===== rtl/rotation_matrix_to_quaternion_core_defines.svh =====
// Assertion macros for the rotation matrix to quaternion core.
// Included by rmq_out_buf, the RTL file that carries concurrent checks; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rmq check failed");
`define RMQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("rmq check failed");
`else
`define RMQ_ASSERT(lbl, clk, rst, prop)
`define RMQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/rmq_pkg.sv =====
// Package for the rotation matrix to quaternion core: widths, codes and types.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;
   localparam int LANES     = 3;
   localparam int D_W       = IN_W + 1;               // sum or difference of two elements
   localparam int RAD_W     = IN_W + 1;               // radicand, 3 * max + ONE
   localparam int SQ_W      = RAD_W + FRAC_BITS;      // radicand scaled by 2^F
   localparam int ROOT_W    = (SQ_W + 1) / 2;
   localparam int DEN_W     = ROOT_W + 1;             // 2 * S
   localparam int NUM_W     = D_W + FRAC_BITS + 1;    // |d| * 2^F + S
   localparam int QB        = IN_W + 1;               // quotient bits before overflow
   localparam int CMP_W     = (DEN_W + QB > NUM_W) ? DEN_W + QB : NUM_W;
   localparam int SUM_W     = RAD_W + 2;

   localparam logic [1:0] POS_W = 2'd0;
   localparam logic [1:0] POS_X = 2'd1;
   localparam logic [1:0] POS_Y = 2'd2;
   localparam logic [1:0] POS_Z = 2'd3;

   typedef logic signed [IN_W-1:0]  elem_type;
   typedef logic signed [D_W-1:0]   diff_type;
   typedef logic signed [OUT_W-1:0] comp_type;

   typedef struct packed {
      logic [1:0]             pos;   // slot that takes s/2
      diff_type [LANES-1:0]   d;     // remaining slots, ascending order
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      side_type         side;
   } front_type;

   typedef struct packed {
      logic [SQ_W-1:0] v;
      logic [SQ_W:0]   res;
      side_type        side;
   } sq_type;

   typedef struct packed {
      logic [CMP_W-1:0] rem;
      logic [QB-1:0]    q;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic [DEN_W-1:0]     den;
      logic [ROOT_W-1:0]    root;
      logic [1:0]           pos;
   } div_type;
endpackage
`default_nettype wire

// ===== rtl/rmq_front.sv =====
// Input stage: trace, branch choice, radicand and the three sums or differences.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front import rmq_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      adv,
   input  wire logic      in_valid,
   input  wire elem_type  mat [9],
   output logic           out_valid,
   output front_type      out_data
);
   localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< FRAC_BITS;

   logic      valid_ff;
   front_type data_ff, data_in;

   function automatic diff_type dsub(input elem_type a, input elem_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   function automatic diff_type dadd(input elem_type a, input elem_type b);
      return diff_type'(a) + diff_type'(b);
   endfunction

   always_comb begin
      logic signed [SUM_W-1:0] trace, rad_s;
      logic [1:0] i;
      trace = SUM_W'(mat[0]) + SUM_W'(mat[4]) + SUM_W'(mat[8]);
      i = 2'd0;
      if (mat[4] > mat[0]) i = 2'd1;
      if (mat[8] > ((i == 2'd1) ? mat[4] : mat[0])) i = 2'd2;
      rad_s = '0;
      data_in = '0;
      if (trace > 0) begin
         rad_s = trace + ONE;
         data_in.side.pos  = POS_W;
         data_in.side.d[0] = dsub(mat[7], mat[5]);
         data_in.side.d[1] = dsub(mat[2], mat[6]);
         data_in.side.d[2] = dsub(mat[3], mat[1]);
      end else begin
         case (i)
            2'd0: begin
               rad_s = ONE + SUM_W'(mat[0]) - (SUM_W'(mat[4]) + SUM_W'(mat[8]));
               data_in.side.pos  = POS_X;
               data_in.side.d[0] = dsub(mat[7], mat[5]);
               data_in.side.d[1] = dadd(mat[1], mat[3]);
               data_in.side.d[2] = dadd(mat[2], mat[6]);
            end
            2'd1: begin
               rad_s = ONE + SUM_W'(mat[4]) - (SUM_W'(mat[8]) + SUM_W'(mat[0]));
               data_in.side.pos  = POS_Y;
               data_in.side.d[0] = dsub(mat[2], mat[6]);
               data_in.side.d[1] = dadd(mat[1], mat[3]);
               data_in.side.d[2] = dadd(mat[5], mat[7]);
            end
            default: begin
               rad_s = ONE + SUM_W'(mat[8]) - (SUM_W'(mat[0]) + SUM_W'(mat[4]));
               data_in.side.pos  = POS_Z;
               data_in.side.d[0] = dsub(mat[3], mat[1]);
               data_in.side.d[1] = dadd(mat[2], mat[6]);
               data_in.side.d[2] = dadd(mat[5], mat[7]);
            end
         endcase
         if (rad_s < 0) rad_s = '0;
      end
      data_in.rad = rad_s[RAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ===== rtl/rmq_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, side data alongside.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_pipe import rmq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire front_type         in_data,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root,
   output side_type               out_side
);
   logic [ROOT_W-1:0] vld_ff;
   sq_type            stg_ff [ROOT_W];
   sq_type            stg_in [ROOT_W];

   always_comb begin
      sq_type        c;
      logic [SQ_W:0] bitv, trial;
      for (int n = 0; n < ROOT_W; n++) begin
         if (n == 0) begin
            c.v    = {in_data.rad, {FRAC_BITS{1'b0}}};
            c.res  = '0;
            c.side = in_data.side;
         end else begin
            c = stg_ff[n-1];
         end
         bitv  = (SQ_W+1)'(1) << (2 * (ROOT_W - 1 - n));
         trial = c.res + bitv;
         stg_in[n] = c;
         if ({1'b0, c.v} >= trial) begin
            stg_in[n].v   = c.v - trial[SQ_W-1:0];
            stg_in[n].res = (c.res >> 1) + bitv;
         end else begin
            stg_in[n].res = c.res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < ROOT_W; n++) stg_ff[n] <= stg_in[n];
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = stg_ff[ROOT_W-1].res[ROOT_W-1:0];
   assign out_side  = stg_ff[ROOT_W-1].side;
endmodule
`default_nettype wire

// ===== rtl/rmq_div_pipe.sv =====
// Three-lane pipelined restoring divider: |d| * 2^F / (2S), rounded, with overflow flag.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_pipe import rmq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [ROOT_W-1:0] in_root,
   input  wire side_type          in_side,
   output logic                   out_valid,
   output div_type                out_data
);
   localparam int NST = QB + 1;

   logic [NST-1:0] vld_ff;
   div_type        stg_ff [NST];
   div_type        stg_in [NST];

   always_comb begin
      div_type          c;
      logic [D_W-1:0]   mag;
      logic [NUM_W-1:0] num;
      logic [CMP_W-1:0] trial;
      // prep: numerator with rounding term, early overflow test
      stg_in[0].den  = {in_root, 1'b0};
      stg_in[0].root = in_root;
      stg_in[0].pos  = in_side.pos;
      for (int l = 0; l < LANES; l++) begin
         mag = in_side.d[l][D_W-1] ? D_W'(-in_side.d[l]) : D_W'(in_side.d[l]);
         num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(in_root);
         stg_in[0].lane[l].neg = in_side.d[l][D_W-1];
         stg_in[0].lane[l].rem = CMP_W'(num);
         stg_in[0].lane[l].q   = '0;
         stg_in[0].lane[l].ovf =
            CMP_W'(num) >= (CMP_W'({in_root, 1'b0}) << QB);
      end
      // one quotient bit per stage, most significant first
      for (int n = 1; n < NST; n++) begin
         c = stg_ff[n-1];
         stg_in[n] = c;
         for (int l = 0; l < LANES; l++) begin
            trial = CMP_W'(c.den) << (QB - n);
            if (c.lane[l].rem >= trial) begin
               stg_in[n].lane[l].rem        = c.lane[l].rem - trial;
               stg_in[n].lane[l].q[QB - n]  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < NST; n++) stg_ff[n] <= stg_in[n];
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_data  = stg_ff[NST-1];
endmodule
`default_nettype wire

// ===== rtl/rmq_out_buf.sv =====
// Result saturation, slot assembly and a two-entry output buffer that drives the stall.
// Depends on rmq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rotation_matrix_to_quaternion_core_defines.svh"
module rmq_out_buf import rmq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire div_type           in_data,
   output logic                   adv,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [4*OUT_W-1:0]     rsp_tdata
);
   localparam logic signed [OUT_W-1:0] SMAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] SMIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic [1:0]         occ_ff, occ_in;
   logic [4*OUT_W-1:0] e0_ff, e0_in, e1_ff, e1_in;
   logic [4*OUT_W-1:0] res;
   logic               push, pop;

   function automatic comp_type sat_lane(input lane_type ln, input logic zero);
      comp_type r;
      if (zero) begin
         r = '0;
      end else if (ln.ovf) begin
         r = ln.neg ? SMIN : SMAX;
      end else if (ln.neg) begin
         r = (ln.q > QB'(1 << (OUT_W - 1))) ? SMIN : -comp_type'(ln.q[OUT_W-1:0]);
      end else begin
         r = (ln.q > QB'(SMAX)) ? SMAX : comp_type'(ln.q[OUT_W-1:0]);
      end
      return r;
   endfunction

   always_comb begin
      logic [ROOT_W:0] half;
      comp_type        h, l0, l1, l2;
      logic            zero;
      zero = (in_data.root == '0);
      half = ({1'b0, in_data.root} + (ROOT_W+1)'(1)) >> 1;
      h    = (half > (ROOT_W+1)'(SMAX)) ? SMAX : comp_type'(half[OUT_W-1:0]);
      l0   = sat_lane(in_data.lane[0], zero);
      l1   = sat_lane(in_data.lane[1], zero);
      l2   = sat_lane(in_data.lane[2], zero);
      case (in_data.pos)
         POS_W:   res = {l2, l1, l0, h};
         POS_X:   res = {l2, l1, h, l0};
         POS_Y:   res = {l2, h, l1, l0};
         default: res = {h, l2, l1, l0};
      endcase
   end

   assign pop  = rsp_tvalid && rsp_tready;
   assign adv  = (occ_ff != 2'd2) || pop;
   assign push = in_valid && adv;

   always_comb begin
      occ_in = occ_ff;
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      if (pop) begin
         e0_in = e1_ff;
      end
      if (push) begin
         if ((occ_ff == 2'd0) || ((occ_ff == 2'd1) && pop)) e0_in = res;
         else e1_in = res;
      end
      occ_in = occ_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 2'd0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign rsp_tvalid = (occ_ff != 2'd0);
   assign rsp_tdata  = e0_ff;

   `RMQ_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (occ_ff == 2'd0))
   `RMQ_ASSERT(a_occ_range, clock, reset, occ_ff != 2'd3)
   `RMQ_ASSERT(a_stall_full, clock, reset, !adv |-> (occ_ff == 2'd2 && !rsp_tready))
   `RMQ_ASSERT(a_full_hold, clock, reset, (occ_ff == 2'd2 && !pop) |=> (occ_ff == 2'd2))
endmodule
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// Top level of the rotation matrix to quaternion core.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_pipe, rmq_div_pipe and rmq_out_buf.
`timescale 1ns / 1ps
`default_nettype none
// Converts one 3x3 rotation matrix (nine signed Q2.14 elements) per request
// into the unit quaternion w, x, y, z in signed Q2.14, Shoemake's method:
// positive trace gives w = sqrt(trace+1)/2, otherwise the largest diagonal
// element (ties to the lower index) picks the component that takes s/2; the
// other three are sums or differences scaled by 0.5/s, rounded to nearest
// (ties away from zero), zero when s is zero, and every output saturates to
// 16 bits. A new request is taken every cycle while the pipeline advances;
// each request reaches rsp_tvalid through one decode stage, 16 square-root
// stages (one root bit each), one divider set-up stage, 17 divider
// stages (one quotient bit each, three lanes side by side) and the output
// buffer. The whole pipeline advances together; a two-entry output buffer
// lets the core keep taking requests while one result waits, and the
// pipeline holds only when both entries are full and rsp_tready is low.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22; 16 bits each from bit 0
   input  wire logic [143:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // qw, qx, qy, qz; 16 bits each from bit 0
   output logic [63:0]        rsp_tdata
);
   logic              adv;
   elem_type          mat [9];
   logic              fr_valid;
   front_type         fr_data;
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;
   logic              dv_valid;
   div_type           dv_data;

   // unpack row-major matrix elements
   always_comb begin
      for (int e = 0; e < 9; e++) mat[e] = elem_type'(req_tdata[e*IN_W +: IN_W]);
   end

   assign req_tready = adv;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .mat       (mat),
      .out_valid (fr_valid),
      .out_data  (fr_data)
   );

   rmq_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_data   (fr_data),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_data  (dv_data)
   );

   rmq_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .in_data    (dv_data),
      .adv        (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire
